// ===== src/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types and constants of the sorted table binary search block
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int POS_W   = 8;

  // request kinds carried on in_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr;        // store one table entry
    logic start;     // load target and search bounds
    logic probe;     // latch mid and issue the table read
    logic narrow;    // move one bound past mid
    logic set_hit;   // record a hit at mid
    logic load_out;  // move the answer into the output register
  } stbs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic live;      // low below the exclusive upper bound
    logic hit;       // probed entry equals the target
    logic out_free;  // output register can take a new answer
  } stbs_sts_t;

endpackage

`default_nettype wire

// ===== src/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl
// sequencer for table writes and binary search probes
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_op,
  output logic                    in_tready,
  output stbs_pkg::stbs_cmd_t     cmd,
  input  wire stbs_pkg::stbs_sts_t sts
);

  import stbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == OP_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = S_PROBE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (sts.live) begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = S_PROBE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/stbs_dp.sv =====
// ----------------------------------------------------------------------------
// stbs_dp
// entry table, search bounds, compare and output register
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [stbs_pkg::COUNT_W-1:0]   cfg_wdata,
  input  wire logic [stbs_pkg::INDEX_W-1:0]   in_index,
  input  wire logic [stbs_pkg::VALUE_W-1:0]   in_value,
  input  wire stbs_pkg::stbs_cmd_t            cmd,
  output stbs_pkg::stbs_sts_t                 sts,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic                                out_found,
  output logic [stbs_pkg::POS_W-1:0]          out_position
);

  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0]        cnt_r;
  logic [CW-1:0]             cnt_sat;
  logic [CW-1:0]             low_r;
  logic [CW-1:0]             hi_r;
  logic [CW-1:0]             mid_r;
  logic [CW-1:0]             mid_c;
  logic signed [VALUE_W-1:0] target_r;
  logic                      found_r;
  logic [POS_W-1:0]          pos_r;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [POS_W-1:0]          out_pos_r;
  logic [VALUE_W-1:0]        ram_rdata;
  logic [AW-1:0]             ram_addr;
  logic                      ram_we;
  logic                      idx_in_range;
  logic                      probe_gt;

  // searches cover at most the whole table
  always_comb begin
    if (32'(cnt_r) > 32'(TABLE_DEPTH)) begin
      cnt_sat = CW'(TABLE_DEPTH);
    end else begin
      cnt_sat = CW'(cnt_r);
    end
  end

  // hi_r is exclusive, so mid = low + (high - low) / 2 with high = hi_r - 1
  assign mid_c = low_r + ((hi_r - low_r - CW'(1)) >> 1);

  assign idx_in_range = ({{(32 - INDEX_W){1'b0}}, in_index} < 32'(TABLE_DEPTH));
  assign ram_we       = cmd.wr && idx_in_range;
  assign ram_addr     = cmd.probe ? mid_c[AW-1:0] : AW'(in_index);

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  assign probe_gt     = $signed(ram_rdata) > target_r;
  assign sts.live     = low_r < hi_r;
  assign sts.hit      = $signed(ram_rdata) == target_r;
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      low_r    <= '0;
      hi_r     <= cnt_sat;
      target_r <= $signed(in_value);
      found_r  <= 1'b0;
      pos_r    <= '0;
    end
    if (cmd.probe) begin
      mid_r <= mid_c;
    end
    if (cmd.narrow) begin
      if (probe_gt) begin
        hi_r <= mid_r;
      end else begin
        low_r <= mid_r + CW'(1);
      end
    end
    if (cmd.set_hit) begin
      found_r <= 1'b1;
      pos_r   <= POS_W'(mid_r);
    end
    if (cmd.load_out) begin
      out_found_r <= found_r;
      out_pos_r   <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

`default_nettype wire

// ===== src/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// binary search over a table of signed 32-bit entries kept in ascending order
// ----------------------------------------------------------------------------
// usage
//   in channel: in_tuser picks the request kind (write or search), in_tdata
//   carries the table index and the value. a write stores one entry and gives
//   no answer; the next request is taken right after. a search gives exactly
//   one answer on the out channel: out_tuser is the found flag, out_tdata the
//   index of the first probe that hit (0 on a miss). cfg_we / cfg_wdata set
//   entry_count, the number of entries searched, saturated to TABLE_DEPTH;
//   write it only while no search is running.
// search sequence
//   each probe issues the table read (registered ram output), then does the
//   compare and bound update. a search makes at most log2(TABLE_DEPTH) + 1
//   probes. in_tready comes back with out_tvalid, so no new request is taken
//   until the answer of the running search is in the output register.
// reset and stall
//   rst_n clears entry_count and the output valid flag; table contents stay
//   undefined until written. the answer sits in an output register, so a new
//   request is taken while it waits; a second answer waits in the datapath,
//   with the controller held, until out_tready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: entry_count
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [7:0] index, [39:8] value
  input  wire logic        in_tuser,   // [0] op
  // answer channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] position
  output logic             out_tuser   // [0] found
);

  import stbs_pkg::*;

  stbs_cmd_t cmd;
  stbs_sts_t sts;

  // sequencer: idle, probe, compare, hand-off
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table ram, search bounds and output register
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_index     (in_tdata[INDEX_W-1:0]),
    .in_value     (in_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_found    (out_tuser),
    .out_position (out_tdata)
  );

  // a search request holds off the request channel on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_SEARCH)) |=> !in_tready)
    else $error("request taken while a search runs");

  // a table write leaves the block ready for the next request
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_WRITE)) |=> in_tready)
    else $error("table write did not finish in one cycle");

  // a miss always reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("miss answer with nonzero position");

  // an answer cannot appear in the cycle right after a search request
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_SEARCH) && !out_tvalid) |=> !out_tvalid)
    else $error("answer appeared without any probe");

endmodule

`default_nettype wire

// ===== verif/sorted_table_binary_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// self-checking bench for the sorted table binary search block
// ----------------------------------------------------------------------------
// table writes and searches go in on the request stream. each accepted write
// updates a copy of the table; each accepted search runs a bench-side search
// over it and a copy of entry_count, and its answer is queued and compared
// field by field with the answer stream. the stimulus never lets a search
// probe an entry that was not written: entry_count is only raised over a
// prefix that has been filled. both streams idle at random, the answer side
// holds off once for a long stretch, and entry_count is written only once the
// block has gone quiet.
// ----------------------------------------------------------------------------

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int DEPTH       = 256;
  localparam int QUIET_WAIT  = 30;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  // dut ports; the ones the bench drives are known from time zero
  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [COUNT_W-1:0]            cfg_wdata  = '0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [VALUE_W+INDEX_W-1:0]    in_tdata   = '0;   // [7:0] index, [39:8] value
  logic                          in_tuser   = 1'b0; // [0] op
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [POS_W-1:0]              out_tdata;         // [7:0] position
  logic                          out_tuser;         // [0] found

  // copy of the block state as seen through accepted requests and cfg writes
  logic signed [VALUE_W-1:0]     entry_copy [0:DEPTH-1];
  logic [COUNT_W-1:0]            count_copy = '0;
  answer_t                       pending_answers [$];

  // what the stimulus has written so far, used only to pick targets
  logic [VALUE_W-1:0]            planned_entries [0:DEPTH-1];
  int                            plan_count = 0;

  bit                            idle_on = 1'b1;
  int                            hold_request = 0;
  int                            mismatch_count = 0;
  int                            cycle_count = 0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // classic binary search over the copied table, same probe order as the block
  function automatic answer_t bsearch_answer(input logic signed [VALUE_W-1:0] target);
    answer_t ans;
    int      span;
    int      lo;
    int      hi;
    int      mid;
    ans  = '0;
    // entry_count above the table depth saturates
    span = (int'(count_copy) > DEPTH) ? DEPTH : int'(count_copy);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi && !ans.found) begin
      mid = lo + (hi - lo) / 2;
      if (entry_copy[mid] == target) begin
        ans.found    = 1'b1;
        ans.position = mid[POS_W-1:0];
      end else if (entry_copy[mid] > target) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return ans;
  endfunction

  // follows every accepted request and checks every accepted answer
  always @(posedge clk) begin : answer_check
    answer_t want;
    if (rst_n) begin
      if (cfg_we) begin
        count_copy = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE) begin
          entry_copy[in_tdata[INDEX_W-1:0]] = in_tdata[INDEX_W +: VALUE_W];
        end else begin
          pending_answers.push_back(bsearch_answer(in_tdata[INDEX_W +: VALUE_W]));
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected answer, expected none, got found %0b position %0d",
                   $time, out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = pending_answers.pop_front();
          if (out_tuser !== want.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_tuser);
            mismatch_count++;
          end
          if (out_tdata !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, out_tdata);
            mismatch_count++;
          end
        end
      end
    end
  end

  // answer side: random stalls, plus a long hold-off on demand
  initial begin : answer_sink
    int stall_len;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall_len    = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
      out_tready <= !idle_on || ($urandom_range(99) >= 8);
    end
  end

  // one request; returns at the edge that accepted it with tvalid still high,
  // so the caller must send again or drop tvalid in the same step
  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val);
    while (idle_on && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, idx};
    if (op == OP_WRITE) begin
      planned_entries[idx] = val;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait for every answer, then for a search in flight
  task automatic drain();
    in_tvalid <= 1'b0;
    // let the checker log the last accepted request first
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  // entry_count changes only on a quiet block
  task automatic set_entry_count(input int n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n[COUNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    plan_count = n;
  endtask

  // entries 0..n-1 in ascending order, step between 0 and spread
  task automatic fill_ascending(input int n, input int unsigned spread);
    longint ceiling;
    longint v;
    longint r;
    ceiling = 64'sd2147483647 - longint'(n) * longint'(spread);
    r       = {32'd0, $urandom};
    v       = -64'sd2147483648 + r % (ceiling + 64'sd2147483649);
    for (int i = 0; i < n; i++) begin
      send_request(OP_WRITE, i[INDEX_W-1:0], v[VALUE_W-1:0]);
      v = v + longint'($urandom_range(spread, 0));
    end
  endtask

  // mostly entries of the table, some neighbors, extremes and noise
  function automatic logic [VALUE_W-1:0] pick_target();
    int          span;
    int unsigned sel;
    span = (plan_count > DEPTH) ? DEPTH : plan_count;
    sel  = $urandom_range(99);
    if (span == 0 || sel < 10) return $urandom;
    if (sel < 20) return sel[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (sel < 40) begin
      return planned_entries[$urandom_range(span - 1)] + (sel[0] ? 32'h1 : 32'hFFFF_FFFF);
    end
    return planned_entries[$urandom_range(span - 1)];
  endfunction

  task automatic search_burst(input int k);
    repeat (k) send_request(OP_SEARCH, INDEX_W'($urandom), pick_target());
  endtask

  // field extremes, hits at both ends, misses, repeated entries, empty table
  task automatic test_directed();
    // entry_count is 0 out of reset: nothing is probed
    send_request(OP_SEARCH, 8'h00, 32'h0000_0000);
    send_request(OP_SEARCH, 8'hFF, 32'h8000_0000);
    send_request(OP_WRITE, 8'd0, 32'h8000_0000);
    send_request(OP_WRITE, 8'd1, 32'hFFFF_FFFB);
    send_request(OP_WRITE, 8'd2, 32'h0000_0000);
    send_request(OP_WRITE, 8'd3, 32'h0000_0007);
    send_request(OP_WRITE, 8'd4, 32'h7FFF_FFFF);
    set_entry_count(5);
    send_request(OP_SEARCH, 8'h00, 32'h8000_0000);
    send_request(OP_SEARCH, 8'h00, 32'hFFFF_FFFB);
    send_request(OP_SEARCH, 8'h00, 32'h0000_0000);
    send_request(OP_SEARCH, 8'h00, 32'h0000_0007);
    send_request(OP_SEARCH, 8'h00, 32'h7FFF_FFFF);
    // misses between entries
    send_request(OP_SEARCH, 8'h00, 32'h0000_0003);
    send_request(OP_SEARCH, 8'h00, 32'hFFFF_FFFA);
    // a run of equal entries: the first probe that hits wins
    send_request(OP_WRITE, 8'd1, 32'h0000_0007);
    send_request(OP_WRITE, 8'd2, 32'h0000_0007);
    send_request(OP_WRITE, 8'd3, 32'h0000_0007);
    send_request(OP_SEARCH, 8'h00, 32'h0000_0007);
    send_request(OP_SEARCH, 8'h00, 32'h0000_0008);
    // single entry table
    set_entry_count(1);
    send_request(OP_SEARCH, 8'h00, 32'h8000_0000);
    send_request(OP_SEARCH, 8'h00, 32'h7FFF_FFFF);
    // two entries, hit on the second probe
    set_entry_count(2);
    send_request(OP_SEARCH, 8'h00, 32'h0000_0007);
  endtask

  // small tables with dense, sparse and repeating contents
  task automatic test_small_tables();
    int          sizes   [8];
    int unsigned spreads [6];
    sizes   = '{1, 2, 3, 5, 8, 13, 16, 31};
    spreads = '{0, 1, 4, 1000, 1 << 20, 1 << 24};
    foreach (sizes[i]) begin
      fill_ascending(sizes[i], spreads[$urandom_range(5)]);
      set_entry_count(sizes[i]);
      search_burst(12);
    end
  endtask

  // full table with no idling, then entry_count past the depth
  task automatic test_full_table();
    idle_on = 1'b0;
    fill_ascending(DEPTH, $urandom_range(1 << 23, 0));
    set_entry_count(DEPTH);
    search_burst(40);
    // saturates to the table depth
    set_entry_count(511);
    search_burst(20);
    set_entry_count(DEPTH - 1);
    search_burst(10);
    drain();
    idle_on = 1'b1;
  endtask

  // answer side holds off so the block fills and stalls its input
  task automatic test_backpressure();
    set_entry_count(DEPTH);
    @(negedge clk);
    hold_request = 300;
    @(posedge clk);
    search_burst(16);
    // sender waits for every answer before going on
    drain();
    set_entry_count(128);
    search_burst(10);
  endtask

  // out-of-order contents: the probe order alone decides the answer
  task automatic test_unsorted();
    set_entry_count(64);
    repeat (40) begin
      if ($urandom_range(1)) begin
        send_request(OP_WRITE, INDEX_W'($urandom_range(63)), $urandom);
      end else begin
        send_request(OP_SEARCH, INDEX_W'($urandom), pick_target());
      end
    end
    // back to an empty table
    set_entry_count(0);
    search_burst(3);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_tables();
    test_full_table();
    test_backpressure();
    test_unsorted();
    drain();
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_ctrl.sv
src/stbs_dp.sv
src/sorted_table_binary_search.sv
verif/sorted_table_binary_search_tb.sv
